[src/tss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, sizes and helpers for the three-stack shared buffer.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int SLOTS_PER_STACK = 256;
    localparam int DATA_WIDTH      = 32;
    localparam int NUM_STACKS      = 3;
    localparam int STORE_SIZE      = NUM_STACKS * SLOTS_PER_STACK;
    localparam int PTR_W           = $clog2(STORE_SIZE);
    localparam int CNT_W           = $clog2(STORE_SIZE + 1);
    localparam int SUM_W           = CNT_W + 2;
    localparam int WORD_W          = 32;

    typedef logic [PTR_W-1:0]      ptr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [1:0]            sid_t;
    typedef logic [DATA_WIDTH-1:0] data_t;

    typedef ptr_t [NUM_STACKS-1:0] ptr_vec_t;
    typedef cnt_t [NUM_STACKS-1:0] cnt_vec_t;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;
    localparam sid_t SID_BAD   = 2'd3;

    typedef enum logic [1:0] {
        ST_OK,
        ST_INVALID,
        ST_OVERFLOW,
        ST_UNDERFLOW
    } status_t;

    typedef struct packed {
        logic              mode;
        logic [1:0]        stack_id;
        logic [WORD_W-1:0] push_value;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] pop_value;
        status_t           status;
    } result_t;

    // Free space bookkeeping handed from the gap unit to the controller
    typedef struct packed {
        ptr_vec_t raw;
        cnt_t     free_words;
    } gap_info_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RAW,
        S_DECIDE,
        S_SH_SRC,
        S_SH_DST,
        S_SHIFT,
        S_SH_END,
        S_PUSH,
        S_POP_RD,
        S_POP_OUT
    } state_t;

    typedef enum logic {
        PH_CHECK,
        PH_SHIFT_A
    } phase_t;

    // Add two positions whose sum is below twice the store size, modulo the store size
    function automatic ptr_t wrap_add(input logic [PTR_W:0] a, input logic [PTR_W:0] b);
        logic [PTR_W+1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PTR_W+2)'(STORE_SIZE))
        begin
            s = s - (PTR_W+2)'(STORE_SIZE);
        end
        return s[PTR_W-1:0];
    endfunction

    // Next stack in circular order
    function automatic sid_t next_sid(input sid_t k);
        return (k == sid_t'(NUM_STACKS - 1)) ? sid_t'(0) : k + sid_t'(1);
    endfunction

endpackage

[src/three_stack_shared_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_stack_shared_buffer
// Three LIFO stacks in one circular store; a push into a full neighbor
// boundary shifts the next stack forward first (else the one after, then it).
//
//   channel  | valid         | stall         | word
//   ---------+---------------+---------------+-------------------------
//   item     | item_valid    | item_stall    | item   (mode, id, value)
//   result   | result_valid  | result_stall  | result (value, status)
//
// One item at a time. Without rebalancing a push passes the raw, decide and
// push states and a pop the raw, decide, pop-read and pop-out states before
// its result is valid. Shifting moves one word per cycle through the store's
// read and write ports; a chained shift moves both stacks and recounts the
// gaps in between. Reset leaves starts at 0, N, 2N and all counts zero; the
// store is not cleared. A stalled result holds off the next item.
// ----------------------------------------------------------------------------
module three_stack_shared_buffer
    import tss_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    state_t    state_reg, state_next;
    phase_t    phase_reg, phase_next;
    item_t     item_reg, item_next;
    ptr_vec_t  start_reg, start_next;
    cnt_vec_t  count_reg, count_next;
    gap_info_t info_reg, info_next;
    sid_t      shk_reg, shk_next;
    ptr_t      d_reg, d_next;
    cnt_t      idx_reg, idx_next;
    ptr_t      src_reg, src_next;
    ptr_t      dst_reg, dst_next;
    ptr_t      wr_addr_reg, wr_addr_next;
    logic      wr_pend_reg, wr_pend_next;
    logic      out_valid_reg, out_valid_next;
    result_t   out_reg, out_next;

    data_t     mem [STORE_SIZE];
    data_t     rd_data_reg;
    logic      mem_we, mem_re;
    ptr_t      mem_waddr, mem_raddr;
    data_t     mem_wdata;

    gap_info_t info_w;
    cnt_t      gap_w [NUM_STACKS];
    logic [PTR_W:0] others;
    sid_t      id, id_a, id_b;
    ptr_t      top_w;

    tss_gap u_gap
    (
        .starts (start_reg),
        .counts (count_reg),
        .info   (info_w)
    );

    // Usable gap ahead of each stack
    always_comb
    begin
        for (int k = 0; k < NUM_STACKS; k++)
        begin
            others = (PTR_W+1)'(info_reg.raw[next_sid(sid_t'(k))])
                   + (PTR_W+1)'(info_reg.raw[next_sid(next_sid(sid_t'(k)))]);
            if (others >= (PTR_W+1)'(info_reg.free_words))
            begin
                gap_w[k] = '0;
            end
            else
            begin
                gap_w[k] = CNT_W'((PTR_W+1)'(info_reg.free_words) - others);
            end
        end
    end

    assign item_stall   = !((state_reg == S_IDLE) && (!out_valid_reg || !result_stall));
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Control and bookkeeping registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_CHECK;
            out_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
            for (int k = 0; k < NUM_STACKS; k++)
            begin
                start_reg[k] <= ptr_t'(k * SLOTS_PER_STACK);
                count_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            wr_pend_reg   <= wr_pend_next;
            start_reg     <= start_next;
            count_reg     <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        info_reg    <= info_next;
        shk_reg     <= shk_next;
        d_reg       <= d_next;
        idx_reg     <= idx_next;
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        wr_addr_reg <= wr_addr_next;
        out_reg     <= out_next;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        item_next      = item_reg;
        start_next     = start_reg;
        count_next     = count_reg;
        info_next      = info_reg;
        shk_next       = shk_reg;
        d_next         = d_reg;
        idx_next       = idx_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        wr_addr_next   = wr_addr_reg;
        wr_pend_next   = wr_pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = wr_addr_reg;
        mem_raddr      = src_reg;
        mem_wdata      = rd_data_reg;
        id             = item_reg.stack_id;
        id_a           = next_sid(id);
        id_b           = next_sid(id_a);
        top_w          = wrap_add((PTR_W+1)'(start_reg[id]), (PTR_W+1)'(count_reg[id]));

        unique case (state_reg)
            S_IDLE:
            begin
                phase_next = PH_CHECK;
                if (item_valid && !item_stall)
                begin
                    item_next  = item;
                    state_next = S_RAW;
                end
            end

            S_RAW:
            begin
                info_next  = info_w;
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                if (id == SID_BAD)
                begin
                    out_next       = '{pop_value: '0, status: ST_INVALID};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (item_reg.mode == MODE_POP)
                begin
                    if (count_reg[id] == '0)
                    begin
                        out_next       = '{pop_value: '0, status: ST_UNDERFLOW};
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        count_next[id] = count_reg[id] - cnt_t'(1);
                        state_next     = S_POP_RD;
                    end
                end
                else if (phase_reg == PH_SHIFT_A)
                begin
                    shk_next   = id_a;
                    d_next     = ptr_t'(gap_w[id_a] >> 1) + ptr_t'(1);
                    idx_next   = count_reg[id_a];
                    state_next = S_SH_SRC;
                end
                else if (gap_w[id] != '0)
                begin
                    state_next = S_PUSH;
                end
                else if (gap_w[id_a] != '0)
                begin
                    shk_next   = id_a;
                    d_next     = ptr_t'(gap_w[id_a] >> 1) + ptr_t'(1);
                    idx_next   = count_reg[id_a];
                    state_next = S_SH_SRC;
                end
                else if (gap_w[id_b] != '0)
                begin
                    shk_next   = id_b;
                    d_next     = ptr_t'(gap_w[id_b] >> 1) + ptr_t'(1);
                    idx_next   = count_reg[id_b];
                    state_next = S_SH_SRC;
                end
                else
                begin
                    out_next       = '{pop_value: '0, status: ST_OVERFLOW};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_SH_SRC:
            begin
                // Topmost word of the stack being moved
                src_next = wrap_add((PTR_W+1)'(start_reg[shk_reg]),
                                    (PTR_W+1)'(count_reg[shk_reg]));
                if (src_next == '0)
                begin
                    src_next = ptr_t'(STORE_SIZE - 1);
                end
                else
                begin
                    src_next = src_next - ptr_t'(1);
                end
                state_next = S_SH_DST;
            end

            S_SH_DST:
            begin
                dst_next     = wrap_add((PTR_W+1)'(src_reg), (PTR_W+1)'(d_reg));
                wr_pend_next = 1'b0;
                state_next   = S_SHIFT;
            end

            S_SHIFT:
            begin
                // Write back the word read last cycle
                mem_we    = wr_pend_reg;
                mem_waddr = wr_addr_reg;
                mem_wdata = rd_data_reg;
                if (idx_reg != '0)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = src_reg;
                    wr_addr_next = dst_reg;
                    wr_pend_next = 1'b1;
                    idx_next     = idx_reg - cnt_t'(1);
                    src_next = (src_reg == '0) ? ptr_t'(STORE_SIZE - 1) : src_reg - ptr_t'(1);
                    dst_next = (dst_reg == '0) ? ptr_t'(STORE_SIZE - 1) : dst_reg - ptr_t'(1);
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg)
                    begin
                        state_next = S_SH_END;
                    end
                end
            end

            S_SH_END:
            begin
                start_next[shk_reg] = wrap_add((PTR_W+1)'(start_reg[shk_reg]),
                                               (PTR_W+1)'(d_reg));
                if (shk_reg == id_a)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    phase_next = PH_SHIFT_A;
                    state_next = S_RAW;
                end
            end

            S_PUSH:
            begin
                mem_we         = 1'b1;
                mem_waddr      = top_w;
                mem_wdata      = item_reg.push_value[DATA_WIDTH-1:0];
                count_next[id] = count_reg[id] + cnt_t'(1);
                out_next       = '{pop_value: '0, status: ST_OK};
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            S_POP_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = top_w;
                state_next = S_POP_OUT;
            end

            S_POP_OUT:
            begin
                out_next       = '{pop_value: WORD_W'(rd_data_reg), status: ST_OK};
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[src/tss_gap.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_gap
// Free space between each stack top and the start of the next stack,
// plus the total number of free words in the store.
// ----------------------------------------------------------------------------
module tss_gap
    import tss_pkg::*;
(
    input  ptr_vec_t  starts,
    input  cnt_vec_t  counts,
    output gap_info_t info
);

    ptr_vec_t         tops;
    logic [SUM_W-1:0] used;

    // Count free words, then the top of each stack and distance to the next start
    always_comb
    begin
        used = SUM_W'(counts[0]) + SUM_W'(counts[1]) + SUM_W'(counts[2]);
        if (used >= SUM_W'(STORE_SIZE))
        begin
            info.free_words = '0;
        end
        else
        begin
            info.free_words = CNT_W'(SUM_W'(STORE_SIZE) - used);
        end
        for (int j = 0; j < NUM_STACKS; j++)
        begin
            tops[j] = wrap_add((PTR_W+1)'(starts[j]), (PTR_W+1)'(counts[j]));
            info.raw[j] = wrap_add((PTR_W+1)'(starts[next_sid(sid_t'(j))]),
                                   (PTR_W+1)'(STORE_SIZE) - (PTR_W+1)'(tops[j]));
        end
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives push, pop and invalid-stack words into the three-stack shared buffer
// and checks each result word against a typed answer (directed rows) or a
// behavioral model of the circular store: per-stack start and count, neighbor
// shifting on a full boundary, chained shifting, overflow and underflow.
// Directed rows, then random traffic filling and draining, with random idling.
// ----------------------------------------------------------------------------
module tb_top
    import tss_pkg::*;
();

    localparam int MAX_IDLE   = 18;
    localparam int N_RANDOM   = 380;
    localparam int DOG_LIMIT  = 20000;
    localparam int TAIL_WAIT  = 4 * STORE_SIZE + 50;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    three_stack_shared_buffer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Model state of the shared store
    logic [WORD_W-1:0] mdl_store [STORE_SIZE];
    int unsigned       mdl_start [NUM_STACKS];
    int unsigned       mdl_count [NUM_STACKS];

    result_t     expected_results [$];
    int          n_errors;
    bit          hold_off;
    bit          stim_done;
    int unsigned quiet_cycles;

    // Directed table; check_fixed marks rows whose answer is typed in
    typedef struct {
        item_t   word;
        bit      check_fixed;
        result_t fixed;
    } row_t;
    row_t dir_rows [$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic int unsigned top_pos(int unsigned k);
        return (mdl_start[k] + mdl_count[k]) % STORE_SIZE;
    endfunction

    function automatic int unsigned span_ahead(int unsigned k);
        return (mdl_start[(k + 1) % NUM_STACKS] + STORE_SIZE - top_pos(k)) % STORE_SIZE;
    endfunction

    function automatic int unsigned room_of(int unsigned k);
        int unsigned used;
        int unsigned free_w;
        int unsigned others;
        used   = mdl_count[0] + mdl_count[1] + mdl_count[2];
        free_w = (used >= STORE_SIZE) ? 0 : STORE_SIZE - used;
        others = span_ahead((k + 1) % NUM_STACKS) + span_ahead((k + 2) % NUM_STACKS);
        return (others >= free_w) ? 0 : free_w - others;
    endfunction

    task automatic move_stack(int unsigned k);
        int unsigned d;
        int unsigned src;
        d = room_of(k) / 2 + 1;
        for (int unsigned i = mdl_count[k]; i > 0; i--)
        begin
            src = (mdl_start[k] + i - 1) % STORE_SIZE;
            mdl_store[(src + d) % STORE_SIZE] = mdl_store[src];
        end
        mdl_start[k] = (mdl_start[k] + d) % STORE_SIZE;
    endtask

    // Compute the result of one word and advance the model
    task automatic predict_stack_op(input item_t w, output result_t r);
        int unsigned id;
        int unsigned a;
        int unsigned b;
        bit          ok;
        id = w.stack_id;
        r.pop_value = '0;
        r.status    = ST_OK;
        if (w.stack_id == SID_BAD)
        begin
            r.status = ST_INVALID;
        end
        else if (w.mode == MODE_PUSH)
        begin
            ok = 1'b1;
            if (room_of(id) == 0)
            begin
                a = (id + 1) % NUM_STACKS;
                b = (id + 2) % NUM_STACKS;
                if (room_of(a) == 0)
                begin
                    if (room_of(b) == 0)
                        ok = 1'b0;
                    else
                        move_stack(b);
                end
                if (ok)
                    move_stack(a);
            end
            if (ok)
            begin
                mdl_store[top_pos(id)] = w.push_value;
                mdl_count[id]++;
            end
            else
            begin
                r.status = ST_OVERFLOW;
            end
        end
        else if (mdl_count[id] == 0)
        begin
            r.status = ST_UNDERFLOW;
        end
        else
        begin
            mdl_count[id]--;
            r.pop_value = mdl_store[top_pos(id)];
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("tb_top: mismatch at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // Offer one word, wait for acceptance, then idle a random count
    task automatic send_word(input item_t w, input int gap);
        item_valid <= 1'b1;
        item       <= w;
        do
            @(posedge clk);
        while (item_stall);
        // Keep valid up when the next word follows at once
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and hold until every expected word has come
    task automatic wait_drained;
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    function automatic item_t make_word(logic m, sid_t s, logic [WORD_W-1:0] v);
        item_t w;
        w.mode       = m;
        w.stack_id   = s;
        w.push_value = v;
        return w;
    endfunction

    function automatic void add_row(item_t w, bit fixed_chk, result_t f);
        row_t r;
        r.word        = w;
        r.check_fixed = fixed_chk;
        r.fixed       = f;
        dir_rows.push_back(r);
    endfunction

    function automatic result_t res(logic [WORD_W-1:0] v, status_t s);
        result_t r;
        r.pop_value = v;
        r.status    = s;
        return r;
    endfunction

    function automatic int draw_gap;
        // Leave some stretches with no idling at all
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // Stimulus
    initial
    begin
        item_t       w;
        result_t     r;
        int          target;
        int unsigned fill;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        hold_off     = 1'b0;
        stim_done    = 1'b0;
        n_errors     = 0;
        for (int k = 0; k < NUM_STACKS; k++)
        begin
            mdl_start[k] = k * SLOTS_PER_STACK;
            mdl_count[k] = 0;
        end
        for (int i = 0; i < STORE_SIZE; i++)
            mdl_store[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: underflow after reset, invalid stack, data extremes
        add_row(make_word(MODE_POP, 2'd0, '0), 1'b1, res('0, ST_UNDERFLOW));
        add_row(make_word(MODE_POP, 2'd2, '1), 1'b1, res('0, ST_UNDERFLOW));
        add_row(make_word(MODE_PUSH, SID_BAD, '1), 1'b1, res('0, ST_INVALID));
        add_row(make_word(MODE_POP, SID_BAD, '0), 1'b1, res('0, ST_INVALID));
        add_row(make_word(MODE_PUSH, 2'd0, '1), 1'b1, res('0, ST_OK));
        add_row(make_word(MODE_PUSH, 2'd0, '0), 1'b1, res('0, ST_OK));
        add_row(make_word(MODE_POP, 2'd0, '0), 1'b1, res('0, ST_OK));
        add_row(make_word(MODE_POP, 2'd0, '0), 1'b1, res('1, ST_OK));
        add_row(make_word(MODE_PUSH, 2'd1, 32'hA5A5_5A5A), 1'b1, res('0, ST_OK));
        add_row(make_word(MODE_PUSH, 2'd2, 32'h8000_0001), 1'b1, res('0, ST_OK));
        add_row(make_word(MODE_POP, 2'd1, '0), 1'b1, res(32'hA5A5_5A5A, ST_OK));
        add_row(make_word(MODE_POP, 2'd2, '0), 1'b1, res(32'h8000_0001, ST_OK));
        add_row(make_word(MODE_POP, 2'd1, '0), 1'b1, res('0, ST_UNDERFLOW));
        foreach (dir_rows[i])
        begin
            predict_stack_op(dir_rows[i].word, r);
            expected_results.push_back(dir_rows[i].check_fixed ? dir_rows[i].fixed : r);
            send_word(dir_rows[i].word, draw_gap());
        end
        wait_drained();

        // Fill stack 0 past its slice: neighbor shift, chained shift, then overflow
        for (int i = 0; i < STORE_SIZE + 2; i++)
        begin
            w = make_word(MODE_PUSH, 2'd0, $urandom());
            predict_stack_op(w, r);
            expected_results.push_back(r);
            send_word(w, 0);
        end
        // Receiver holds off while the sender keeps offering
        hold_off = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            w = make_word(MODE_POP, sid_t'($urandom_range(0, 2)), $urandom());
            predict_stack_op(w, r);
            expected_results.push_back(r);
            send_word(w, 0);
        end
        wait_drained();

        // Random: phases that grow or shrink one stack, mixed with noise
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 100 == 0)
            begin
                target = $urandom_range(0, 2);
                fill   = $urandom_range(0, 1);
            end
            if ($urandom_range(0, 19) == 0)
                w = make_word(1'($urandom_range(0, 1)), SID_BAD, $urandom());
            else if ($urandom_range(0, 3) != 0)
                w = make_word(fill ? MODE_PUSH : MODE_POP, sid_t'(target), $urandom());
            else
                w = make_word(1'($urandom_range(0, 1)), sid_t'($urandom_range(0, 2)),
                              $urandom());
            predict_stack_op(w, r);
            expected_results.push_back(r);
            send_word(w, (n % 300 < 150) ? draw_gap() : 0);
            if (n == N_RANDOM / 2)
                wait_drained();
        end
        wait_drained();
        stim_done = 1'b1;
    end

    // Receiver stall: random wait after each word, plus one long hold-off
    initial
    begin
        int n_wait;
        bit held;
        result_stall = 1'b0;
        held         = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off && !held)
            begin
                held = 1'b1;
                result_stall <= 1'b1;
                repeat (600) @(posedge clk);
                result_stall <= 1'b0;
                @(posedge clk);
            end
            else if (result_valid && !result_stall)
            begin
                n_wait = $urandom_range(0, MAX_IDLE);
                if (n_wait != 0)
                begin
                    result_stall <= 1'b1;
                    repeat (n_wait) @(posedge clk);
                    result_stall <= 1'b0;
                end
                @(posedge clk);
            end
            else
            begin
                @(posedge clk);
            end
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result word with nothing expected");
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.pop_value !== want.pop_value)
                    report_mismatch($sformatf("pop_value %h, want %h",
                                              result.pop_value, want.pop_value));
                if (result.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              result.status, want.status));
            end
        end
    end

    // Watchdog on cycles with no acceptance on either side
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // End of run
    initial
    begin
        fork
            begin
                wait (stim_done);
                repeat (TAIL_WAIT) @(posedge clk);
                if (n_errors == 0 && expected_results.size() == 0)
                    $display("tb_top: done, clean");
                else
                    $display("tb_top: done, errors");
            end
            begin
                wait (quiet_cycles >= DOG_LIMIT);
                $display("tb_top: timeout");
                $display("tb_top: done, errors");
            end
        join_any
        $finish;
    end

endmodule
